// ----- design/assert_macros.svh -----
// Assertion macros shared by the RLE encoder modules.
// Standalone header; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that prop holds at every rising edge of clk outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Checks that cond is never true at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- design/rlde_pkg.sv -----
// Package for the run-length decimal encoder: command type, queue sizing and the
// powers-of-ten table. No dependencies.
`default_nettype none

package rlde_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // One flush request: a run byte with its length, and optionally a single
    // byte run that follows it when the stream ends.
    typedef struct packed {
        logic [7:0]  a_byte;
        logic [15:0] a_len;
        logic        b_valid;
        logic [7:0]  b_byte;
        logic        last;
    } t_cmd;

    function automatic logic [15:0] pow10(input logic [2:0] pos);
        logic [15:0] p;
        unique case (pos)
            3'd0:    p = 16'd1;
            3'd1:    p = 16'd10;
            3'd2:    p = 16'd100;
            3'd3:    p = 16'd1000;
            3'd4:    p = 16'd10000;
            default: p = 16'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- design/rlde_front.sv -----
// Front part of the RLE encoder: tracks the open run and turns each input byte
// into at most one flush command. Uses rlde_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rlde_front #(
    parameter int unsigned MAX_RUN = 65535
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire  [7:0]          i_byte,
    input  wire                 i_last,
    input  wire                 i_full,
    output logic                o_stall,
    output logic                o_push,
    output rlde_pkg::t_cmd      o_cmd
);
    import rlde_pkg::*;

    localparam logic [15:0] RUN_CAP =
        (MAX_RUN > 32'd65535) ? 16'hFFFF : ((MAX_RUN < 32'd2) ? 16'd2 : 16'(MAX_RUN));

    logic [7:0]  r_val, n_val;
    logic [15:0] r_len, n_len;
    logic        r_open, n_open;
    logic        accept;
    t_cmd        cmd;
    logic        has_flush;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        cmd       = '0;
        has_flush = 1'b0;
        n_val     = r_val;
        n_len     = r_len;
        cmd.last  = i_last;
        if (!r_open) begin
            n_val      = i_byte;
            n_len      = 16'd1;
            has_flush  = i_last;
            cmd.a_byte = i_byte;
            cmd.a_len  = 16'd1;
        end else if (i_byte == r_val && r_len < RUN_CAP) begin
            n_len      = r_len + 16'd1;
            has_flush  = i_last;
            cmd.a_byte = i_byte;
            cmd.a_len  = r_len + 16'd1;
        end else begin
            has_flush   = 1'b1;
            cmd.a_byte  = r_val;
            cmd.a_len   = r_len;
            cmd.b_valid = i_last;
            cmd.b_byte  = i_byte;
            n_val       = i_byte;
            n_len       = 16'd1;
        end
        n_open = !i_last;
        if (i_last) begin
            n_val = 8'd0;
            n_len = 16'd0;
        end
    end

    assign o_push = accept && has_flush;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= 8'd0;
            r_len  <= 16'd0;
            r_open <= 1'b0;
        end else if (accept) begin
            r_val  <= n_val;
            r_len  <= n_len;
            r_open <= n_open;
        end
    end

    `ASSERT_PROP(a_run_len_range, i_clk, i_rst_n,
        r_open |-> (r_len != 16'd0 && r_len <= RUN_CAP))

endmodule

`default_nettype wire

// ----- design/rlde_fifo.sv -----
// Short command queue between the front and back parts of the RLE encoder.
// Uses rlde_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rlde_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  rlde_pkg::t_cmd      i_cmd,
    input  wire                 i_pop,
    output rlde_pkg::t_cmd      o_cmd,
    output logic                o_empty,
    output logic                o_full
);
    import rlde_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_CW-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_cmd;
                r_wr        <= r_wr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty)
    `ASSERT_PROP(a_cnt_bound, i_clk, i_rst_n, r_cnt <= FIFO_CW'(FIFO_DEPTH))

endmodule

`default_nettype wire

// ----- design/rlde_back.sv -----
// Back part of the RLE encoder: expands flush commands into the run byte and its
// decimal digits, one byte per cycle unless stalled, into o_byte. Uses rlde_pkg.
`default_nettype none
`include "assert_macros.svh"

module rlde_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rlde_pkg::t_cmd      i_cmd,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [7:0]          o_byte,
    output logic                o_burst_end,
    output logic                o_stream_end,
    output logic [31:0]         o_compressed_length
);
    import rlde_pkg::*;

    typedef enum logic [1:0] {
        S_A,
        S_DIG,
        S_B
    } t_back_state;

    t_back_state r_state;
    logic        r_busy;
    logic [7:0]  r_a_byte;
    logic [15:0] r_rem;
    logic [2:0]  r_pos;
    logic        r_has_dig;
    logic        r_b_valid;
    logic [7:0]  r_b_byte;
    logic        r_last;
    logic [31:0] r_total;
    logic        r_o_valid;
    logic [7:0]  r_o_byte;
    logic        r_o_burst;
    logic        r_o_stream;
    logic [31:0] r_o_len;

    logic [16:0] p17;
    logic [16:0] thr;
    logic [16:0] sub;
    logic [3:0]  digit;
    logic [7:0]  cur;
    logic        fin;
    logic        adv;
    logic        ld;
    logic [2:0]  head_pos;

    always_comb begin
        p17   = {1'b0, pow10(r_pos)};
        thr   = '0;
        digit = 4'd0;
        sub   = '0;
        for (int k = 1; k < 10; k++) begin
            thr = 17'(k) * p17;
            if ({1'b0, r_rem} >= thr) begin
                digit = 4'(k);
                sub   = thr;
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_A: begin
                cur = r_a_byte;
                fin = !r_has_dig && !r_b_valid;
            end
            S_DIG: begin
                cur = ASCII_ZERO + {4'd0, digit};
                fin = (r_pos == 3'd0) && !r_b_valid;
            end
            S_B: begin
                cur = r_b_byte;
                fin = 1'b1;
            end
            default: begin
                cur = r_a_byte;
                fin = 1'b1;
            end
        endcase
    end

    always_comb begin
        priority if (i_cmd.a_len >= 16'd10000) begin
            head_pos = 3'd4;
        end else if (i_cmd.a_len >= 16'd1000) begin
            head_pos = 3'd3;
        end else if (i_cmd.a_len >= 16'd100) begin
            head_pos = 3'd2;
        end else if (i_cmd.a_len >= 16'd10) begin
            head_pos = 3'd1;
        end else begin
            head_pos = 3'd0;
        end
    end

    assign adv   = r_busy && (!r_o_valid || !i_stall);
    assign ld    = !i_empty && (!r_busy || (adv && fin));
    assign o_pop = ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_state   <= S_A;
            r_o_valid <= 1'b0;
            r_total   <= 32'd0;
        end else begin
            if (adv) begin
                r_o_valid  <= 1'b1;
                r_o_byte   <= cur;
                r_o_burst  <= fin;
                r_o_stream <= fin && r_last;
                r_o_len    <= r_total + 32'd1;
                r_total    <= (fin && r_last) ? 32'd0 : r_total + 32'd1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (ld) begin
                r_busy    <= 1'b1;
                r_state   <= S_A;
                r_a_byte  <= i_cmd.a_byte;
                r_rem     <= i_cmd.a_len;
                r_pos     <= head_pos;
                r_has_dig <= i_cmd.a_len > 16'd1;
                r_b_valid <= i_cmd.b_valid;
                r_b_byte  <= i_cmd.b_byte;
                r_last    <= i_cmd.last;
            end else if (adv) begin
                if (fin) begin
                    r_busy <= 1'b0;
                end else begin
                    unique case (r_state)
                        S_A: r_state <= r_has_dig ? S_DIG : S_B;
                        S_DIG: begin
                            r_rem <= r_rem - sub[15:0];
                            if (r_pos == 3'd0) begin
                                r_state <= S_B;
                            end else begin
                                r_pos <= r_pos - 3'd1;
                            end
                        end
                        S_B: r_busy <= 1'b0;
                        default: r_busy <= 1'b0;
                    endcase
                end
            end
        end
    end

    assign o_valid             = r_o_valid;
    assign o_byte              = r_o_byte;
    assign o_burst_end         = r_o_burst;
    assign o_stream_end        = r_o_stream;
    assign o_compressed_length = r_o_len;

    `ASSERT_PROP(a_digit_range, i_clk, i_rst_n,
        (r_busy && r_state == S_DIG) |-> ({1'b0, r_rem} < 17'(10) * p17))

endmodule

`default_nettype wire

// ----- design/run_length_decimal_encoder.sv -----
// Run-length encoder with decimal counts: top level joining front, queue and back.
// Depends on rlde_pkg, rlde_front, rlde_fifo and rlde_back.
//
// Input channel: i_in_valid with i_in_byte and i_in_last, stalled by o_in_stall.
// A transaction is taken at a clock edge with valid high and stall low. Bytes
// that only extend the open run produce no output. A byte that ends a run queues
// one command for the run byte and its length in ASCII decimal digits, if over 1.
// Output channel: o_out_valid with the byte, burst and stream end flags and the
// running compressed length, stalled by i_out_stall.
// An accepted transaction is queued, loaded by the back part and registered at the
// output. The input side takes one transaction per cycle while the four-entry
// command queue has room; the output side delivers one byte per cycle unless
// stalled, so a burst of up to seven bytes stalls the input only once the queue
// fills. A stalled output holds its transaction until it is taken.
// Reset (synchronous, active low) closes the open run, empties the queue, clears
// the output register and restarts the compressed length at zero.
`default_nettype none

module run_length_decimal_encoder #(
    parameter int unsigned MAX_RUN = 65535
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_in_last,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_out_burst_end,
    output logic        o_out_stream_end,
    output logic [31:0] o_out_compressed_length,
    input  wire         i_out_stall
);
    import rlde_pkg::*;

    logic push;
    logic pop;
    logic empty;
    logic full;
    t_cmd push_cmd;
    t_cmd head_cmd;

    rlde_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    rlde_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    rlde_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (head_cmd),
        .i_empty             (empty),
        .o_pop               (pop),
        .o_valid             (o_out_valid),
        .i_stall             (i_out_stall),
        .o_byte              (o_out_byte),
        .o_burst_end         (o_out_burst_end),
        .o_stream_end        (o_out_stream_end),
        .o_compressed_length (o_out_compressed_length)
    );

endmodule

`default_nettype wire

// ----- dv/tb_run_length_decimal_encoder.sv -----
// Self-checking testbench for run_length_decimal_encoder: directed and random byte
// streams, with a scoreboard class that predicts every encoded byte.
// Depends on rlde_pkg and the run_length_decimal_encoder RTL.
module tb_run_length_decimal_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_RUN        = 65535;
    localparam int unsigned RANDOM_ITEMS   = 350;
    localparam int unsigned CALM_ITEMS     = 80;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [7:0]  code;
        logic        burst_end;
        logic        stream_end;
        logic [31:0] length;
    } t_rle_code;

    class rle_scoreboard;
        bit [7:0]    run_byte;
        int unsigned run_len;
        bit          run_active;
        bit [31:0]   emitted;
        int unsigned run_cap;
        int unsigned fail_count;
        t_rle_code   encoded_q[$];

        function new(int unsigned max_run);
            run_cap    = (max_run > 65535) ? 65535 : ((max_run < 2) ? 2 : max_run);
            run_byte   = 8'h00;
            run_len    = 0;
            run_active = 1'b0;
            emitted    = 32'd0;
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return encoded_q.size();
        endfunction

        function void emit(bit [7:0] code);
            t_rle_code c;
            emitted      = emitted + 32'd1;
            c.code       = code;
            c.burst_end  = 1'b0;
            c.stream_end = 1'b0;
            c.length     = emitted;
            encoded_q    = {encoded_q, c};
        endfunction

        function void flush_run();
            bit [7:0]    digits[5];
            int          nd;
            int unsigned v;
            nd = 0;
            v  = run_len;
            emit(run_byte);
            if (v > 1) begin
                while (v != 0 && nd < 5) begin
                    digits[nd] = rlde_pkg::ASCII_ZERO + 8'(v % 10);
                    nd++;
                    v = v / 10;
                end
                for (int i = nd - 1; i >= 0; i--) begin
                    emit(digits[i]);
                end
            end
        endfunction

        function void encode_byte(bit [7:0] b, bit last);
            int unsigned first_idx;
            t_rle_code   c;
            first_idx = encoded_q.size();
            if (!run_active) begin
                run_byte   = b;
                run_len    = 1;
                run_active = 1'b1;
            end else if (b == run_byte && run_len < run_cap) begin
                run_len++;
            end else begin
                flush_run();
                run_byte = b;
                run_len  = 1;
            end
            if (last) begin
                flush_run();
                run_active   = 1'b0;
                run_len      = 0;
                run_byte     = 8'h00;
                c            = encoded_q[encoded_q.size() - 1];
                c.stream_end = 1'b1;
                encoded_q[encoded_q.size() - 1] = c;
                emitted      = 32'd0;
            end
            if (encoded_q.size() > first_idx) begin
                c           = encoded_q[encoded_q.size() - 1];
                c.burst_end = 1'b1;
                encoded_q[encoded_q.size() - 1] = c;
            end
        endfunction

        function void check_code(logic [7:0] code, logic burst_end, logic stream_end,
                                 logic [31:0] length);
            t_rle_code e;
            if (encoded_q.size() == 0) begin
                $error("out_byte: expected nothing, got %h", code);
                fail_count++;
                return;
            end
            e = encoded_q.pop_front();
            if (code !== e.code) begin
                $error("out_byte: expected %h, got %h", e.code, code);
                fail_count++;
            end
            if (burst_end !== e.burst_end) begin
                $error("burst_end: expected %b, got %b", e.burst_end, burst_end);
                fail_count++;
            end
            if (stream_end !== e.stream_end) begin
                $error("stream_end: expected %b, got %b", e.stream_end, stream_end);
                fail_count++;
            end
            if (length !== e.length) begin
                $error("compressed_length: expected %0d, got %0d", e.length, length);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_in_byte  = 8'h00;
    logic        i_in_last  = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_out_burst_end;
    logic        o_out_stream_end;
    logic [31:0] o_out_compressed_length;

    rle_scoreboard sb;
    int unsigned   in_idle_pct   = 0;
    int unsigned   out_stall_pct = 0;
    int unsigned   items_sent    = 0;
    int unsigned   quiet_cycles  = 0;
    bit [7:0]      prev_run_byte = 8'h00;

    run_length_decimal_encoder #(
        .MAX_RUN(MAX_RUN)
    ) uut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .i_in_byte               (i_in_byte),
        .i_in_last               (i_in_last),
        .o_in_stall              (o_in_stall),
        .o_out_valid             (o_out_valid),
        .o_out_byte              (o_out_byte),
        .o_out_burst_end         (o_out_burst_end),
        .o_out_stream_end        (o_out_stream_end),
        .o_out_compressed_length (o_out_compressed_length),
        .i_out_stall             (i_out_stall)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always begin
        @(negedge i_clk);
        if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
            i_out_stall = 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        bit in_taken;
        bit out_taken;
        in_taken  = i_rst_n && i_in_valid && !o_in_stall;
        out_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (in_taken) begin
            sb.encode_byte(i_in_byte, i_in_last);
        end
        if (out_taken) begin
            sb.check_code(o_out_byte, o_out_burst_end, o_out_stream_end,
                          o_out_compressed_length);
        end
        if (in_taken || out_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        i_in_last  = last;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_run(input logic [7:0] b, input int unsigned len, input logic last);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(b, last && (i == len - 1));
        end
    endtask

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 40;
        endcase
    endfunction

    task automatic random_stream(input int unsigned n_runs);
        logic [7:0]  b;
        int unsigned len;
        int unsigned p;
        for (int unsigned r = 0; r < n_runs; r++) begin
            case ($urandom_range(0, 3))
                0:       b = 8'($urandom_range(0, 255));
                1:       b = rlde_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
                2:       b = prev_run_byte;
                default: b = prev_run_byte ^ (8'h01 << $urandom_range(0, 7));
            endcase
            p = $urandom_range(0, 99);
            if (p < 60) begin
                len = $urandom_range(1, 3);
            end else if (p < 85) begin
                len = $urandom_range(4, 12);
            end else if (p < 97) begin
                len = $urandom_range(13, 40);
            end else begin
                len = $urandom_range(100, 130);
            end
            prev_run_byte = b;
            send_run(b, len, r == n_runs - 1);
        end
    endtask

    initial begin
        int unsigned random_base;
        sb = new(MAX_RUN);
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        in_idle_pct   = 20;
        out_stall_pct = 20;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_run(8'h41, 2, 1'b1);
        send_run(8'h31, 3, 1'b0);
        send_run(8'h32, 2, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        send_run(8'h7E, 10, 1'b0);
        send_byte(8'h00, 1'b1);

        // A long run closed by a new byte on the last transaction gives a burst
        // of the run byte, three digits and the closing byte.
        in_idle_pct   = 5;
        out_stall_pct = 10;
        send_run(8'h5A, 120, 1'b0);
        send_byte(8'hA5, 1'b1);

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS - CALM_ITEMS) begin
            in_idle_pct   = pick_idle_pct();
            out_stall_pct = pick_idle_pct();
            random_stream($urandom_range(1, 8));
        end
        in_idle_pct   = 0;
        out_stall_pct = 0;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            random_stream($urandom_range(1, 8));
        end
        i_in_valid = 1'b0;
        i_in_last  = 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ----- run_length_decimal_encoder.f -----
+incdir+design
design/rlde_pkg.sv
design/rlde_front.sv
design/rlde_fifo.sv
design/rlde_back.sv
design/run_length_decimal_encoder.sv
dv/tb_run_length_decimal_encoder.sv
